/* design/spq_pkg.sv */
// shared types and constants for the sorted priority queue
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CAP_W     = 6;
  localparam int PID_W     = 16;
  localparam int PRIO_W    = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              cmd;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CAP_W-1:0]  entry_count;
    logic              head_valid;
    logic [PID_W-1:0]  head_pid;
    logic [PRIO_W-1:0] head_priority;
    logic [PID_W-1:0]  tail_pid;
    logic [PRIO_W-1:0] tail_priority;
  } rsp_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* design/spq_cell.sv */
// one slot of the queue: holds an entry and shifts toward its neighbors
`default_nettype none
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic [CW-1:0] count,
  input  wire entry_t    left,
  input  wire logic      ge_left,
  input  wire entry_t    right,
  output entry_t         entry,
  output logic           ge
);

  entry_t entry_next;
  logic   live;

  assign live = count > CW'(IDX);
  // new item goes behind this slot
  assign ge   = live && (ctl.item.prio >= entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.enq) begin
      if (ge) begin
        entry_next = entry;
      end else if (ge_left) begin
        entry_next = ctl.item;
      end else begin
        entry_next = left;
      end
    end else if (ctl.deq) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

/* design/sorted_priority_queue.sv */
// sorted priority queue built as a chain of shifting slots
// result: done rises in the cycle after the start transfer
// throughput: one command per cycle, busy stays low; all slots compare in parallel
// reset: live count cleared, capacity register set to 32, no result pending
// slot contents are not cleared by reset
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  output logic                  done,
  output rsp_t                  rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  entry_t           tail;
  entry_t           tail_next;
  entry_t           head_next;
  entry_t           cells [DEPTH];
  logic             ge [DEPTH];
  cell_ctl_t        ctl;
  logic             accept;
  logic             full;
  logic             empty;
  logic [1:0]       status_next;
  entry_t           new_item;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign new_item = '{pid: req.pid, prio: req.priority_req};

  assign full  = (MW'(count) >= MW'(capacity)) || (count >= CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl         = '{enq: 1'b0, deq: 1'b0, item: new_item};
    status_next = ST_DONE;
    count_next  = count;
    tail_next   = tail;
    head_next   = cells[0];
    if (req.cmd == CMD_ENQ) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        ctl.enq    = accept;
        count_next = count + CW'(1);
        if (!ge[0]) begin
          head_next = new_item;
        end
        if (empty || (req.priority_req >= tail.prio)) begin
          tail_next = new_item;
        end
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        ctl.deq    = accept;
        count_next = count - CW'(1);
        head_next  = cells[1];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left;
    logic   ge_left;
    entry_t right;
    if (i == 0) begin : g_first
      assign left    = new_item;
      assign ge_left = 1'b1;
    end else begin : g_mid
      assign left    = cells[i-1];
      assign ge_left = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_inner
      assign right = cells[i+1];
    end
    spq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count),
      .left    (left),
      .ge_left (ge_left),
      .right   (right),
      .entry   (cells[i]),
      .ge      (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
      end
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tail                <= tail_next;
      rsp.status          <= status_next;
      rsp.entry_count     <= CAP_W'(count_next);
      rsp.head_valid      <= (count_next != '0);
      rsp.head_pid        <= (count_next != '0) ? head_next.pid : '0;
      rsp.head_priority   <= (count_next != '0) ? head_next.prio : '0;
      rsp.tail_pid        <= (count_next != '0) ? tail_next.pid : '0;
      rsp.tail_priority   <= (count_next != '0) ? tail_next.prio : '0;
    end
  end

endmodule
`default_nettype wire

/* design/spq_checker.sv */
// port-level checks for the sorted priority queue and their bind
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t rsp
);

  a_done_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after a transfer");

  a_no_spurious_done: assert property (@(posedge clk)
    !(start && !busy) |=> !done)
    else $error("result without a transfer");

  a_head_valid_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.head_valid == (rsp.entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.head_valid) |->
      (rsp.head_pid == '0 && rsp.head_priority == '0 &&
       rsp.tail_pid == '0 && rsp.tail_priority == '0))
    else $error("empty queue shows an entry");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_DONE || rsp.status == ST_FULL || rsp.status == ST_EMPTY))
    else $error("bad status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire
